// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on i_clk and off while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DNPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define DNPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/dnps_pkg.sv -----
// ---------------------------------------------------------------------------
// dnps_pkg
// types and constants shared by the directional point select block
// ---------------------------------------------------------------------------
package dnps_pkg;

    localparam int COORD_W = 15;
    localparam int INDEX_W = 16;
    localparam int SCORE_W = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = (SQ_W + 1 > 26) ? SQ_W + 1 : 26;

    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;

    localparam int MIN_JUMP  = 'h0100;
    localparam int MAX_JUMP  = 'h1400;
    localparam int MAX_PERP  = 'h07FF;

    localparam logic [SUM_W-1:0]   MIN_JUMP_SQ = SUM_W'(MIN_JUMP * MIN_JUMP);
    localparam logic [SUM_W-1:0]   MAX_JUMP_SQ = SUM_W'(MAX_JUMP * MAX_JUMP);
    localparam logic [COORD_W-1:0] PERP_LIMIT  = COORD_W'(MAX_PERP);
    localparam logic [SCORE_W-1:0] EMPTY_SCORE = '1;
    localparam logic [SCORE_W-1:0] MAX_SCORE   =
        SCORE_W'((1 << COORD_W) - 1 + 2 * MAX_PERP);

    typedef enum logic [2:0] {
        REG_CURSOR_X     = 3'd0,
        REG_CURSOR_Y     = 3'd1,
        REG_DIRECTION    = 3'd2,
        REG_IGNORE_INDEX = 3'd3,
        REG_RANGE_FILTER = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        DIR_LEFT       = 3'd0,
        DIR_RIGHT      = 3'd1,
        DIR_UP         = 3'd2,
        DIR_DOWN       = 3'd3,
        DIR_UP_LEFT    = 3'd4,
        DIR_UP_RIGHT   = 3'd5,
        DIR_DOWN_LEFT  = 3'd6,
        DIR_DOWN_RIGHT = 3'd7
    } t_dir;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        t_dir               direction;
        logic [INDEX_W-1:0] ignore_index;
        logic               range_filter_on;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [INDEX_W-1:0] point_index;
        logic               has_point;
        logic               first_of_search;
        logic               last_of_search;
    } t_pt;

    typedef struct packed {
        logic [SQ_W-1:0]    sq_x;
        logic [SQ_W-1:0]    sq_y;
        logic               cand;
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] point_index;
        logic               first;
        logic               last;
    } t_eval;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               found;
        logic [SCORE_W-1:0] chosen_score;
    } t_res;

endpackage

// ----- rtl/core/dnps_if.sv -----
// ---------------------------------------------------------------------------
// dnps_if
// valid/ready channels for candidate points and selection results
// ---------------------------------------------------------------------------
interface dnps_pt_if;
    logic                        valid;
    logic                        ready;
    logic [dnps_pkg::COORD_W-1:0] point_x;
    logic [dnps_pkg::COORD_W-1:0] point_y;
    logic [dnps_pkg::INDEX_W-1:0] point_index;
    logic                        has_point;
    logic                        first_of_search;
    logic                        last_of_search;

    modport source (
        output valid, point_x, point_y, point_index, has_point,
               first_of_search, last_of_search,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_index, has_point,
               first_of_search, last_of_search,
        output ready
    );
endinterface

interface dnps_res_if;
    logic                        valid;
    logic                        ready;
    logic [dnps_pkg::INDEX_W-1:0] chosen_index;
    logic                        found;
    logic [dnps_pkg::SCORE_W-1:0] chosen_score;

    modport source (
        output valid, chosen_index, found, chosen_score,
        input  ready
    );
    modport sink (
        input  valid, chosen_index, found, chosen_score,
        output ready
    );
endinterface

// ----- rtl/core/directional_nearest_point_select.sv -----
// ---------------------------------------------------------------------------
// directional_nearest_point_select
// keeps the best candidate point in the configured direction from the cursor
// ---------------------------------------------------------------------------
// path: a last item passes r_in and r_mid; r_out then holds its result on o_res
// throughput: one item per cycle; a last item, and the items behind it, wait only
//   while an earlier result is held in the output register and not yet taken
// reset: synchronous active low; clears valids, kept best and registers
//   (range filter on, all else zero)
module directional_nearest_point_select (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dnps_pt_if.sink                     i_pt,
    dnps_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dnps_pkg::APB_AW-1:0] paddr,
    input  logic [dnps_pkg::APB_DW-1:0] pwdata,
    output logic [dnps_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    `include "assert_macros.svh"

    dnps_pkg::t_cfg  cfg;
    dnps_pkg::t_eval eval;

    logic            r_in_valid;
    dnps_pkg::t_pt   r_in;
    logic            r_mid_valid;
    dnps_pkg::t_eval r_mid;
    logic            r_out_valid;
    logic            n_out_valid;
    dnps_pkg::t_res  r_out;
    dnps_pkg::t_res  n_out;
    logic [dnps_pkg::SCORE_W-1:0] r_best_score;
    logic [dnps_pkg::SCORE_W-1:0] n_best_score;
    logic [dnps_pkg::INDEX_W-1:0] r_best_point;
    logic [dnps_pkg::INDEX_W-1:0] n_best_point;

    logic                         in_free;
    logic                         mid_free;
    logic                         mid_fire;
    logic [dnps_pkg::SUM_W-1:0]   dist_sq;
    logic                         range_ok;
    logic [dnps_pkg::SCORE_W-1:0] base_score;
    logic [dnps_pkg::INDEX_W-1:0] base_point;
    logic                         take;

    dnps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dnps_eval u_eval (
        .i_item (r_in),
        .i_cfg  (cfg),
        .o_eval (eval)
    );

    // stall a last item only when it meets a full output register that o_res does not take
    assign mid_free = !r_mid_valid || !r_mid.last || !r_out_valid || o_res.ready;
    assign in_free  = !r_in_valid || mid_free;
    assign mid_fire = r_mid_valid && mid_free;
    assign i_pt.ready = in_free;

    assign dist_sq  = dnps_pkg::SUM_W'(r_mid.sq_x) + dnps_pkg::SUM_W'(r_mid.sq_y);
    assign range_ok = !cfg.range_filter_on ||
                      ((dist_sq > dnps_pkg::MIN_JUMP_SQ) &&
                       (dist_sq < dnps_pkg::MAX_JUMP_SQ));

    assign base_score = r_mid.first ? dnps_pkg::EMPTY_SCORE : r_best_score;
    assign base_point = r_mid.first ? '0 : r_best_point;
    assign take       = r_mid.cand && range_ok && (r_mid.score < base_score);

    always_comb begin
        n_best_score = r_best_score;
        n_best_point = r_best_point;
        if (mid_fire) begin
            n_best_score = take ? r_mid.score : base_score;
            n_best_point = take ? r_mid.point_index : base_point;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (mid_fire && r_mid.last) begin
            n_out_valid        = 1'b1;
            n_out.chosen_index = n_best_point;
            n_out.found        = (n_best_point != '0);
            n_out.chosen_score = n_best_score;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mid_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_best_score <= dnps_pkg::EMPTY_SCORE;
            r_best_point <= '0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_pt.valid;
            end
            if (mid_free) begin
                r_mid_valid <= r_in_valid;
            end
            r_out_valid  <= n_out_valid;
            r_best_score <= n_best_score;
            r_best_point <= n_best_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in.point_x         <= i_pt.point_x;
            r_in.point_y         <= i_pt.point_y;
            r_in.point_index     <= i_pt.point_index;
            r_in.has_point       <= i_pt.has_point;
            r_in.first_of_search <= i_pt.first_of_search;
            r_in.last_of_search  <= i_pt.last_of_search;
        end
        if (mid_free) begin
            r_mid <= eval;
        end
        r_out <= n_out;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.chosen_index = r_out.chosen_index;
    assign o_res.found        = r_out.found;
    assign o_res.chosen_score = r_out.chosen_score;

    `DNPS_ASSERT_IMP(a_found_matches_score, r_out_valid,
        r_out.found == (r_out.chosen_score != dnps_pkg::EMPTY_SCORE))
    `DNPS_ASSERT_IMP(a_score_bounded, r_out_valid && r_out.found,
        r_out.chosen_score <= dnps_pkg::MAX_SCORE)
    `DNPS_ASSERT_NXT(a_last_held_on_stall,
        r_mid_valid && r_mid.last && r_out_valid && !o_res.ready,
        r_mid_valid && r_mid.last && r_out_valid)
    `DNPS_ASSERT_IMP(a_best_empty_after_reset, $past(!i_rst_n),
        r_best_score == dnps_pkg::EMPTY_SCORE && r_best_point == '0)

endmodule

// ----- rtl/core/dnps_cfg.sv -----
// ---------------------------------------------------------------------------
// dnps_cfg
// apb register file for cursor, direction, ignored index and range filter
// ---------------------------------------------------------------------------
module dnps_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dnps_pkg::APB_AW-1:0]   paddr,
    input  logic [dnps_pkg::APB_DW-1:0]   pwdata,
    output logic [dnps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output dnps_pkg::t_cfg                o_cfg
);

    dnps_pkg::t_cfg     r_cfg;
    dnps_pkg::t_cfg     n_cfg;
    dnps_pkg::t_cfg_reg reg_sel;
    logic               wr_en;

    assign reg_sel = dnps_pkg::t_cfg_reg'(paddr[dnps_pkg::APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                dnps_pkg::REG_CURSOR_X:     n_cfg.cursor_x =
                    pwdata[dnps_pkg::COORD_W-1:0];
                dnps_pkg::REG_CURSOR_Y:     n_cfg.cursor_y =
                    pwdata[dnps_pkg::COORD_W-1:0];
                dnps_pkg::REG_DIRECTION:    n_cfg.direction =
                    dnps_pkg::t_dir'(pwdata[2:0]);
                dnps_pkg::REG_IGNORE_INDEX: n_cfg.ignore_index =
                    pwdata[dnps_pkg::INDEX_W-1:0];
                dnps_pkg::REG_RANGE_FILTER: n_cfg.range_filter_on = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            dnps_pkg::REG_CURSOR_X:     prdata = dnps_pkg::APB_DW'(r_cfg.cursor_x);
            dnps_pkg::REG_CURSOR_Y:     prdata = dnps_pkg::APB_DW'(r_cfg.cursor_y);
            dnps_pkg::REG_DIRECTION:    prdata = dnps_pkg::APB_DW'(r_cfg.direction);
            dnps_pkg::REG_IGNORE_INDEX: prdata = dnps_pkg::APB_DW'(r_cfg.ignore_index);
            dnps_pkg::REG_RANGE_FILTER: prdata = dnps_pkg::APB_DW'(r_cfg.range_filter_on);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cursor_x        <= '0;
            r_cfg.cursor_y        <= '0;
            r_cfg.direction       <= dnps_pkg::DIR_LEFT;
            r_cfg.ignore_index    <= '0;
            r_cfg.range_filter_on <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/dnps_eval.sv -----
// ---------------------------------------------------------------------------
// dnps_eval
// per-point offsets, squared distances, direction weights and score
// ---------------------------------------------------------------------------
module dnps_eval (
    input  dnps_pkg::t_pt   i_item,
    input  dnps_pkg::t_cfg  i_cfg,
    output dnps_pkg::t_eval o_eval
);

    localparam int CW = dnps_pkg::COORD_W;

    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic                 neg_x;
    logic                 neg_y;
    logic                 pos_x;
    logic                 pos_y;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;
    logic [CW:0]          diag_sum;
    logic [CW-1:0]        diag_diff;
    logic [CW-1:0]        along;
    logic [CW-1:0]        perp;
    logic                 dir_ok;
    logic                 idx_ok;
    logic                 oblique;
    logic [CW+1:0]        score_wide;

    assign dx    = $signed({1'b0, i_item.point_x}) - $signed({1'b0, i_cfg.cursor_x});
    assign dy    = $signed({1'b0, i_item.point_y}) - $signed({1'b0, i_cfg.cursor_y});
    assign neg_x = dx[CW];
    assign neg_y = dy[CW];
    assign pos_x = !neg_x && (dx != '0);
    assign pos_y = !neg_y && (dy != '0);
    assign ax    = neg_x ? CW'(-dx) : CW'(dx);
    assign ay    = neg_y ? CW'(-dy) : CW'(dy);

    assign diag_sum  = {1'b0, ax} + {1'b0, ay};
    assign diag_diff = (ax >= ay) ? (ax - ay) : (ay - ax);

    always_comb begin
        case (i_cfg.direction)
            dnps_pkg::DIR_LEFT: begin
                dir_ok = neg_x;  along = ax;  perp = ay;
            end
            dnps_pkg::DIR_RIGHT: begin
                dir_ok = pos_x;  along = ax;  perp = ay;
            end
            dnps_pkg::DIR_UP: begin
                dir_ok = neg_y;  along = ay;  perp = ax;
            end
            dnps_pkg::DIR_DOWN: begin
                dir_ok = pos_y;  along = ay;  perp = ax;
            end
            dnps_pkg::DIR_UP_LEFT: begin
                dir_ok = neg_x && neg_y;
                along  = diag_sum[CW:1];
                perp   = diag_diff >> 1;
            end
            dnps_pkg::DIR_UP_RIGHT: begin
                dir_ok = pos_x && neg_y;
                along  = diag_sum[CW:1];
                perp   = diag_diff >> 1;
            end
            dnps_pkg::DIR_DOWN_LEFT: begin
                dir_ok = neg_x && pos_y;
                along  = diag_sum[CW:1];
                perp   = diag_diff >> 1;
            end
            default: begin
                dir_ok = pos_x && pos_y;
                along  = diag_sum[CW:1];
                perp   = diag_diff >> 1;
            end
        endcase
    end

    assign idx_ok  = (i_item.point_index != '0) &&
                     (i_item.point_index != i_cfg.ignore_index);
    assign oblique = ({1'b0, perp} >= {along, 1'b0}) || (perp > dnps_pkg::PERP_LIMIT);

    assign score_wide = {2'b00, along} + {1'b0, perp, 1'b0};

    assign o_eval.sq_x        = ax * ax;
    assign o_eval.sq_y        = ay * ay;
    assign o_eval.cand        = i_item.has_point && idx_ok && dir_ok &&
                                (along != '0) && !oblique;
    assign o_eval.score       = dnps_pkg::SCORE_W'(score_wide);
    assign o_eval.point_index = i_item.point_index;
    assign o_eval.first       = i_item.first_of_search;
    assign o_eval.last        = i_item.last_of_search;

endmodule
